// ----- rtl/fra_pkg.sv -----
// ============================================================================
// fra_pkg
// Types and constants shared by the frequency residency accumulator blocks.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package fra_pkg;

  localparam int FREQ_W    = 32;
  localparam int TIME_W    = 32;
  localparam int PERIOD_W  = 16;
  localparam int ACC_W     = 64;
  // A 16-bit millisecond period times 1000 stays below 2^26.
  localparam int WIN_W     = 26;
  localparam int PROD_W    = WIN_W + TIME_W;
  localparam int DIV_CNT_W = $clog2(PROD_W + 1);

  localparam logic [9:0]       US_PER_MS = 10'd1000;
  localparam logic [WIN_W-1:0] MS_TO_US  = WIN_W'(US_PER_MS);

  typedef enum logic {
    OP_UPDATE = 1'b0,
    OP_READ   = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_ACCEPTED = 3'd0,
    ST_IGNORED  = 3'd1,
    ST_FULL     = 3'd2,
    ST_REFUSED  = 3'd3,
    ST_ENTRY    = 3'd4,
    ST_EMPTY    = 3'd5
  } status_t;

  typedef struct packed {
    op_t                 operation;
    logic [FREQ_W-1:0]   freq;
    logic [TIME_W-1:0]   busy_span;
    logic [TIME_W-1:0]   total_span;
    logic [PERIOD_W-1:0] period_ms;
  } in_item_t;

  typedef struct packed {
    status_t           status;
    logic [FREQ_W-1:0] entry_freq;
    logic [ACC_W-1:0]  entry_run_us;
    logic [ACC_W-1:0]  entry_idle_us;
    logic              last;
  } out_item_t;

  typedef struct packed {
    logic [FREQ_W-1:0] freq;
    logic [ACC_W-1:0]  run_us;
    logic [ACC_W-1:0]  idle_us;
  } entry_t;

  typedef struct packed {
    logic              start;
    logic [PROD_W-1:0] dividend;
    logic [TIME_W-1:0] divisor;
  } div_ctl_t;

  typedef struct packed {
    logic             done;
    logic [WIN_W-1:0] quotient;
  } div_sts_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_DIV_START,
    S_DIV_WAIT,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_APPEND,
    S_EMIT,
    S_DR_RD,
    S_DR_OUT
  } fra_state_t;

endpackage

`default_nettype wire

// ----- rtl/fra_div.sv -----
// ============================================================================
// fra_div
// Restoring divider, one quotient bit per cycle, for the run-time share.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module fra_div (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire fra_pkg::div_ctl_t ctl,
  output fra_pkg::div_sts_t      sts
);

  logic                            busy_r, busy_nxt;
  logic                            done_r, done_nxt;
  logic [fra_pkg::DIV_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [fra_pkg::TIME_W-1:0]      rem_r, rem_nxt;
  logic [fra_pkg::TIME_W-1:0]      dsr_r, dsr_nxt;
  logic [fra_pkg::PROD_W-1:0]      dvd_r, dvd_nxt;
  logic [fra_pkg::WIN_W-1:0]       quo_r, quo_nxt;
  logic [fra_pkg::TIME_W:0]        trial;
  logic [fra_pkg::TIME_W:0]        diff;
  logic                            ge;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
    dvd_r <= dvd_nxt;
    quo_r <= quo_nxt;
  end

  always_comb begin
    trial    = {rem_r, dvd_r[fra_pkg::PROD_W-1]};
    diff     = trial - {1'b0, dsr_r};
    ge       = (trial >= {1'b0, dsr_r});
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    dvd_nxt  = dvd_r;
    quo_nxt  = quo_r;
    if (ctl.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = fra_pkg::DIV_CNT_W'(fra_pkg::PROD_W);
      rem_nxt  = '0;
      dsr_nxt  = ctl.divisor;
      dvd_nxt  = ctl.dividend;
      quo_nxt  = '0;
    end else if (busy_r) begin
      // The remainder always stays below the divisor, so 32 bits hold it.
      rem_nxt = ge ? diff[fra_pkg::TIME_W-1:0] : trial[fra_pkg::TIME_W-1:0];
      dvd_nxt = {dvd_r[fra_pkg::PROD_W-2:0], 1'b0};
      // The quotient never exceeds the window, so its upper bits are zero.
      quo_nxt = {quo_r[fra_pkg::WIN_W-2:0], ge};
      cnt_nxt = cnt_r - fra_pkg::DIV_CNT_W'(1);
      if (cnt_r == fra_pkg::DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  assign sts.done     = done_r;
  assign sts.quotient = quo_r;

endmodule

`default_nettype wire

// ----- rtl/fra_table.sv -----
// ============================================================================
// fra_table
// Residency entry store: one write port and one registered read port.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module fra_table #(
  parameter int DEPTH  = 16,
  parameter int ADDR_W = 4
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire fra_pkg::entry_t   wr_data,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output fra_pkg::entry_t        rd_data
);

  fra_pkg::entry_t mem [DEPTH];
  fra_pkg::entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ----- rtl/freq_residency_accumulator_unit.sv -----
// ============================================================================
// freq_residency_accumulator_unit
// Per-frequency busy/idle residency table with serial search and divide.
// ============================================================================
//
//   Port group | Dir | Handshake          | Beat contents
//   -----------+-----+--------------------+------------------------------
//   in_        | in  | in_valid/in_ready  | update sample or read request
//   out_       | out | out_valid/out_ready| status, entry fields, last
//   cfg_       | in  | cfg_we             | stats_enable
//
// An update runs one multiply, the bit-serial divider, then a search that
// reads and compares the used entries in turn (S_SRCH_RD, S_SRCH_CMP), as the
// entry store has a single read port. A read drains entries in turn through
// S_DR_RD and S_DR_OUT. Rejected items go straight to S_EMIT. Reset empties the
// table at once through the fill count; there is no clearing pass. A stalled
// result beat holds the sequencer until it is taken; the output register
// lets the next item be accepted while the final beat is still waiting.
//
`timescale 1ns / 1ps
`default_nettype none

module freq_residency_accumulator_unit #(
  parameter int TABLE_ENTRIES = 16
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire fra_pkg::in_item_t   in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output fra_pkg::out_item_t       out_data,
  input  wire logic                cfg_we,
  input  wire logic                cfg_wdata
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  fra_pkg::fra_state_t             state_r, state_nxt;
  logic                            en_r, en_nxt;
  logic [CNT_W-1:0]                count_r, count_nxt;
  logic [IDX_W-1:0]                idx_r, idx_nxt;
  logic [fra_pkg::FREQ_W-1:0]      freq_r, freq_nxt;
  logic [fra_pkg::TIME_W-1:0]      busy_r, busy_nxt;
  logic [fra_pkg::TIME_W-1:0]      total_r, total_nxt;
  logic [fra_pkg::WIN_W-1:0]       window_r, window_nxt;
  logic [fra_pkg::PROD_W-1:0]      prod_r, prod_nxt;
  fra_pkg::status_t                status_r, status_nxt;
  logic                            out_valid_r, out_valid_nxt;
  fra_pkg::out_item_t              out_data_r, out_data_nxt;

  fra_pkg::div_ctl_t               div_ctl;
  fra_pkg::div_sts_t               div_sts;
  logic                            tbl_wr_en;
  logic [IDX_W-1:0]                tbl_wr_addr;
  fra_pkg::entry_t                 tbl_wr_data;
  fra_pkg::entry_t                 tbl_rd_data;

  logic                            out_free;
  logic [CNT_W-1:0]                idx_inc;
  logic [fra_pkg::ACC_W-1:0]       base_run;
  logic [fra_pkg::ACC_W-1:0]       base_idle;
  logic [fra_pkg::WIN_W-1:0]       idle_part;

  fra_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (div_ctl),
    .sts   (div_sts)
  );

  fra_table #(
    .DEPTH  (TABLE_ENTRIES),
    .ADDR_W (IDX_W)
  ) u_table (
    .clk     (clk),
    .wr_en   (tbl_wr_en),
    .wr_addr (tbl_wr_addr),
    .wr_data (tbl_wr_data),
    .rd_addr (idx_r),
    .rd_data (tbl_rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fra_pkg::S_IDLE;
      en_r        <= 1'b0;
      count_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      en_r        <= en_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
    freq_r     <= freq_nxt;
    busy_r     <= busy_nxt;
    total_r    <= total_nxt;
    window_r   <= window_nxt;
    prod_r     <= prod_nxt;
    status_r   <= status_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    out_free  = !out_valid_r || out_ready;
    idx_inc   = CNT_W'(idx_r) + CNT_W'(1);
    idle_part = window_r - div_sts.quotient;
    // A matching entry accumulates onto its stored totals; a new one starts at zero.
    base_run  = (state_r == fra_pkg::S_SRCH_CMP) ? tbl_rd_data.run_us  : '0;
    base_idle = (state_r == fra_pkg::S_SRCH_CMP) ? tbl_rd_data.idle_us : '0;

    state_nxt     = state_r;
    en_nxt        = cfg_we ? cfg_wdata : en_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    freq_nxt      = freq_r;
    busy_nxt      = busy_r;
    total_nxt     = total_r;
    window_nxt    = window_r;
    prod_nxt      = prod_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    in_ready      = 1'b0;

    div_ctl.start    = 1'b0;
    div_ctl.dividend = prod_r;
    div_ctl.divisor  = total_r;

    tbl_wr_en           = 1'b0;
    tbl_wr_addr         = idx_r;
    tbl_wr_data.freq    = freq_r;
    tbl_wr_data.run_us  = base_run + fra_pkg::ACC_W'(div_sts.quotient);
    tbl_wr_data.idle_us = base_idle + fra_pkg::ACC_W'(idle_part);

    case (state_r)
      fra_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          freq_nxt   = in_data.freq;
          total_nxt  = in_data.total_span;
          busy_nxt   = (in_data.busy_span > in_data.total_span) ?
                       in_data.total_span : in_data.busy_span;
          window_nxt = fra_pkg::WIN_W'(in_data.period_ms) * fra_pkg::MS_TO_US;
          idx_nxt    = '0;
          if (in_data.operation == fra_pkg::OP_READ) begin
            if (!en_r) begin
              status_nxt = fra_pkg::ST_REFUSED;
              state_nxt  = fra_pkg::S_EMIT;
            end else if (count_r == '0) begin
              status_nxt = fra_pkg::ST_EMPTY;
              state_nxt  = fra_pkg::S_EMIT;
            end else begin
              state_nxt = fra_pkg::S_DR_RD;
            end
          end else if (!en_r || in_data.freq == '0 || in_data.total_span == '0) begin
            status_nxt = fra_pkg::ST_IGNORED;
            state_nxt  = fra_pkg::S_EMIT;
          end else begin
            state_nxt = fra_pkg::S_MUL;
          end
        end
      end
      fra_pkg::S_MUL: begin
        prod_nxt  = fra_pkg::PROD_W'(window_r) * fra_pkg::PROD_W'(busy_r);
        state_nxt = fra_pkg::S_DIV_START;
      end
      fra_pkg::S_DIV_START: begin
        div_ctl.start = 1'b1;
        state_nxt     = fra_pkg::S_DIV_WAIT;
      end
      fra_pkg::S_DIV_WAIT: begin
        if (div_sts.done) begin
          state_nxt = (count_r == '0) ? fra_pkg::S_APPEND : fra_pkg::S_SRCH_RD;
        end
      end
      fra_pkg::S_SRCH_RD: begin
        state_nxt = fra_pkg::S_SRCH_CMP;
      end
      fra_pkg::S_SRCH_CMP: begin
        if (tbl_rd_data.freq == freq_r) begin
          tbl_wr_en  = 1'b1;
          status_nxt = fra_pkg::ST_ACCEPTED;
          state_nxt  = fra_pkg::S_EMIT;
        end else if (idx_inc == count_r) begin
          state_nxt = fra_pkg::S_APPEND;
        end else begin
          idx_nxt   = idx_inc[IDX_W-1:0];
          state_nxt = fra_pkg::S_SRCH_RD;
        end
      end
      fra_pkg::S_APPEND: begin
        if (count_r == CNT_W'(TABLE_ENTRIES)) begin
          status_nxt = fra_pkg::ST_FULL;
        end else begin
          tbl_wr_en   = 1'b1;
          tbl_wr_addr = count_r[IDX_W-1:0];
          count_nxt   = count_r + CNT_W'(1);
          status_nxt  = fra_pkg::ST_ACCEPTED;
        end
        state_nxt = fra_pkg::S_EMIT;
      end
      fra_pkg::S_EMIT: begin
        if (out_free) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.status        = status_r;
          out_data_nxt.entry_freq    = '0;
          out_data_nxt.entry_run_us  = '0;
          out_data_nxt.entry_idle_us = '0;
          out_data_nxt.last          = 1'b1;
          state_nxt                  = fra_pkg::S_IDLE;
        end
      end
      fra_pkg::S_DR_RD: begin
        state_nxt = fra_pkg::S_DR_OUT;
      end
      fra_pkg::S_DR_OUT: begin
        // The read address holds at idx_r, so the entry stays valid while stalled.
        if (out_free) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.status        = fra_pkg::ST_ENTRY;
          out_data_nxt.entry_freq    = tbl_rd_data.freq;
          out_data_nxt.entry_run_us  = tbl_rd_data.run_us;
          out_data_nxt.entry_idle_us = tbl_rd_data.idle_us;
          out_data_nxt.last          = (idx_inc == count_r);
          if (idx_inc == count_r) begin
            count_nxt = '0;
            state_nxt = fra_pkg::S_IDLE;
          end else begin
            idx_nxt   = idx_inc[IDX_W-1:0];
            state_nxt = fra_pkg::S_DR_RD;
          end
        end
      end
      default: begin
        state_nxt = fra_pkg::S_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ----- rtl/fra_checker.sv -----
// ============================================================================
// fra_checker
// Port-level checks on the residency accumulator, bound to the top level.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module fra_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire fra_pkg::out_item_t out_data
);

  // A result beat that is not taken must hold.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // Every accepted item moves the sequencer out of S_IDLE, so the block is busy after an accepted beat.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted on consecutive cycles");

  // Only entry beats of a drain may leave last low.
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != fra_pkg::ST_ENTRY |-> out_data.last)
    else $error("status beat without last");

  a_status_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != fra_pkg::ST_ENTRY |->
      out_data.entry_freq == '0 && out_data.entry_run_us == '0 &&
      out_data.entry_idle_us == '0)
    else $error("status beat carries entry data");

  // Zero frequencies are never stored, so a drained entry has a real frequency.
  a_entry_freq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == fra_pkg::ST_ENTRY |-> out_data.entry_freq != '0)
    else $error("drained entry with zero frequency");

endmodule

bind freq_residency_accumulator_unit fra_checker u_fra_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

// ----- tb/freq_residency_accumulator_unit_tb.sv -----
// ============================================================================
// freq_residency_accumulator_unit_tb
// Checks the residency table against a cycle-free model of the per-frequency
// busy/idle sums: directed corner samples first, then random phases with the
// statistics switched on and off, random input gaps and output back-pressure, one
// long output stall and one full drain in the middle of a phase.
// ============================================================================
`timescale 1ns / 1ps

module freq_residency_accumulator_unit_tb;

  localparam int TABLE_SLOTS = 16;
  localparam int POOL_MAX    = 24;
  localparam int LONG_HOLD   = 400;
  localparam int SETTLE      = 150;
  localparam int CYCLE_LIMIT = 400000;

  // Expected beats are worked out from a software copy of the table.
  class residency_scoreboard;
    bit                 enable;
    logic [31:0]        freq_of[TABLE_SLOTS];
    logic [63:0]        run_us_of[TABLE_SLOTS];
    logic [63:0]        idle_us_of[TABLE_SLOTS];
    int                 used;
    fra_pkg::out_item_t expected_beats[$];
    int                 errors;

    function new();
      enable = 1'b0;
      errors = 0;
      clear_table();
    endfunction

    function void clear_table();
      for (int i = 0; i < TABLE_SLOTS; i++) begin
        freq_of[i]    = '0;
        run_us_of[i]  = '0;
        idle_us_of[i] = '0;
      end
      used = 0;
    endfunction

    function void set_enable(bit value);
      enable = value;
    endfunction

    function int pending();
      return expected_beats.size();
    endfunction

    function void push_beat(fra_pkg::status_t st, logic [31:0] f, logic [63:0] run_us,
                            logic [63:0] idle_us, bit last);
      fra_pkg::out_item_t beat;
      beat.status        = st;
      beat.entry_freq    = f;
      beat.entry_run_us  = run_us;
      beat.entry_idle_us = idle_us;
      beat.last          = last;
      expected_beats.push_back(beat);
    endfunction

    function void predict_update(fra_pkg::in_item_t item);
      int          slot;
      logic [31:0] busy;
      logic [63:0] window_us;
      logic [63:0] run_us;
      slot = -1;
      if (!enable || item.freq == '0 || item.total_span == '0) begin
        push_beat(fra_pkg::ST_IGNORED, '0, '0, '0, 1'b1);
        return;
      end
      for (int i = 0; i < used; i++) begin
        if (slot < 0 && freq_of[i] == item.freq) slot = i;
      end
      if (slot < 0) begin
        if (used >= TABLE_SLOTS) begin
          push_beat(fra_pkg::ST_FULL, '0, '0, '0, 1'b1);
          return;
        end
        slot = used;
        freq_of[slot]    = item.freq;
        run_us_of[slot]  = '0;
        idle_us_of[slot] = '0;
        used++;
      end
      busy      = (item.busy_span > item.total_span) ? item.total_span : item.busy_span;
      window_us = 64'(item.period_ms) * 64'd1000;
      run_us    = (window_us * 64'(busy)) / 64'(item.total_span);
      run_us_of[slot]  += run_us;
      idle_us_of[slot] += window_us - run_us;
      push_beat(fra_pkg::ST_ACCEPTED, '0, '0, '0, 1'b1);
    endfunction

    function void predict_read();
      if (!enable) begin
        push_beat(fra_pkg::ST_REFUSED, '0, '0, '0, 1'b1);
        return;
      end
      if (used == 0) begin
        push_beat(fra_pkg::ST_EMPTY, '0, '0, '0, 1'b1);
      end else begin
        for (int i = 0; i < used; i++) begin
          push_beat(fra_pkg::ST_ENTRY, freq_of[i], run_us_of[i], idle_us_of[i],
                    i == used - 1);
        end
      end
      clear_table();
    endfunction

    function void note_accepted(fra_pkg::in_item_t item);
      if (item.operation == fra_pkg::OP_READ) predict_read();
      else predict_update(item);
    endfunction

    function void compare_field(string field, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $error("%s mismatch: expected 0x%0h, actual 0x%0h", field, want, got);
        errors++;
      end
    endfunction

    function void check_beat(fra_pkg::out_item_t got);
      fra_pkg::out_item_t want;
      if (expected_beats.size() == 0) begin
        $error("result beat with nothing expected: status %0d freq 0x%0h",
               got.status, got.entry_freq);
        errors++;
        return;
      end
      want = expected_beats.pop_front();
      compare_field("status", 64'(want.status), 64'(got.status));
      compare_field("entry_freq", 64'(want.entry_freq), 64'(got.entry_freq));
      compare_field("entry_run_us", want.entry_run_us, got.entry_run_us);
      compare_field("entry_idle_us", want.entry_idle_us, got.entry_idle_us);
      compare_field("last", 64'(want.last), 64'(got.last));
    endfunction
  endclass

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  fra_pkg::in_item_t  in_data   = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  fra_pkg::out_item_t out_data;
  logic               cfg_we    = 1'b0;
  logic               cfg_wdata = 1'b0;

  residency_scoreboard sb = new();

  bit          idling       = 1'b1;
  bit          hold_request = 1'b0;
  logic [31:0] freq_pool[POOL_MAX];
  int          pool_size    = 1;
  int          cycle_count  = 0;

  freq_residency_accumulator_unit #(
    .TABLE_ENTRIES(TABLE_SLOTS)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_beat(out_data);
  end

  // Result side: short random stalls, plus one long hold on request.
  initial begin
    @(posedge clk iff rst_n);
    out_ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        out_ready <= 1'b1;
      end else if (idling && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  function automatic fra_pkg::in_item_t make_update(logic [31:0] f, logic [31:0] busy,
                                                    logic [31:0] total,
                                                    logic [15:0] period);
    fra_pkg::in_item_t item;
    item.operation  = fra_pkg::OP_UPDATE;
    item.freq       = f;
    item.busy_span  = busy;
    item.total_span = total;
    item.period_ms  = period;
    return item;
  endfunction

  // The sample fields of a read are don't-care, so they carry noise.
  function automatic fra_pkg::in_item_t make_read();
    fra_pkg::in_item_t item;
    item = make_update($urandom, $urandom, $urandom, 16'($urandom));
    item.operation = fra_pkg::OP_READ;
    return item;
  endfunction

  function automatic fra_pkg::in_item_t random_item();
    fra_pkg::in_item_t item;
    int                pick;
    pick = $urandom_range(0, 99);
    if (pick < 8) return make_read();
    item = make_update(freq_pool[$urandom_range(0, pool_size - 1)], '0, '0,
                       16'($urandom));
    case ($urandom_range(0, 3))
      0: begin
        item.busy_span  = $urandom;
        item.total_span = $urandom;
      end
      1: begin
        item.total_span = $urandom_range(1, 1000);
        item.busy_span  = $urandom_range(0, 1200);
      end
      2: begin
        item.total_span = $urandom;
        item.busy_span  = item.total_span;
      end
      default: begin
        item.total_span = $urandom_range(1, 1 << 20);
        item.busy_span  = 32'hFFFF_FFFF - $urandom_range(0, 15);
      end
    endcase
    case ($urandom_range(0, 9))
      0: item.period_ms = '0;
      1: item.period_ms = 16'hFFFF;
      default: ;
    endcase
    if (pick < 13) item.freq = '0;
    else if (pick < 18) item.total_span = '0;
    return item;
  endfunction

  task automatic refresh_pool(input int size);
    logic [31:0] f;
    pool_size = size;
    for (int i = 0; i < POOL_MAX; i++) begin
      f = $urandom;
      freq_pool[i] = (f == '0) ? 32'd1 : f;
    end
    freq_pool[0] = 32'hFFFF_FFFF;
  endtask

  task automatic offer_item(input fra_pkg::in_item_t item);
    if (idling && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    sb.note_accepted(item);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Every item yields at least one beat, so an empty queue means the
  // sequencer is idle and the register may be written.
  task automatic write_enable(input bit value);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_enable(value);
  endtask

  initial begin
    bit phase_enable[6];
    int phase_items[6];
    phase_enable = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
    phase_items  = '{60, 20, 70, 60, 14, 60};

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Statistics are off after reset: updates are ignored, reads refused.
    offer_item(make_update(32'd1000, 32'd5, 32'd10, 16'd100));
    offer_item(make_read());
    write_enable(1'b1);

    offer_item(make_read());
    offer_item(make_update(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF));
    offer_item(make_update(32'd0, 32'd1, 32'd2, 16'd10));
    offer_item(make_update(32'd7, 32'd1, 32'd0, 16'd10));
    offer_item(make_update(32'd1, 32'hFFFF_FFFF, 32'd1, 16'd250));
    offer_item(make_update(32'h8000_0000, 32'd0, 32'd3, 16'd0));
    offer_item(make_update(32'hFFFF_FFFF, 32'd1, 32'd3, 16'd1));
    for (int i = 0; i < TABLE_SLOTS - 3; i++) begin
      offer_item(make_update(32'h5A5A_0000 + i, $urandom, $urandom, 16'($urandom)));
    end
    // The table is now full: a new frequency is dropped, a known one still adds.
    offer_item(make_update(32'h1234_5678, 32'd4, 32'd8, 16'd20));
    offer_item(make_update(32'd1, 32'd7, 32'd9, 16'd40));
    offer_item(make_read());
    offer_item(make_read());

    for (int p = 0; p < 6; p++) begin
      write_enable(phase_enable[p]);
      refresh_pool((p % 2 == 1) ? $urandom_range(17, POOL_MAX) : $urandom_range(4, 16));
      idling = (p != 5);
      for (int n = 0; n < phase_items[p]; n++) begin
        if (p == 3 && n == 0) hold_request = 1'b1;
        if (p == 2 && n == 35) wait_drained();
        offer_item(random_item());
      end
    end

    wait_drained();
    repeat (SETTLE) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/fra_pkg.sv
rtl/fra_div.sv
rtl/fra_table.sv
rtl/freq_residency_accumulator_unit.sv
rtl/fra_checker.sv
tb/freq_residency_accumulator_unit_tb.sv
